[rtl/tcd_pkg.sv]
// shared types, constants and coefficient tables for the cnr to db converter
`timescale 1ns / 1ps
package tcd_pkg;

	typedef logic signed [57:0] acc_t;
	typedef logic signed [31:0] p_t;
	typedef logic [28:0] log_t;

	typedef struct packed {
		logic valid;
		logic active;
		logic is_sat;
		logic big;
	} ctl_t;

	localparam logic [1:0] MODE_TERR = 2'd1;
	localparam logic [1:0] MODE_SAT  = 2'd2;

	localparam int N_STEP = 5;

	localparam acc_t ACC_LIMIT = 58'sd72057594037927936;
	localparam p_t P_MAX = 32'sh7fffffff;
	localparam logic [28:0] LOG10_2_Q30 = 29'd323228497;
	localparam logic [31:0] SAT_OFFSET = 32'd3000;

	// terrestrial quartic padded with a leading zero so both modes run five steps
	localparam acc_t TERR_COEF [N_STEP+1] = '{
		58'sd0, 58'sd15728640, -58'sd104857600,
		58'sd260833280, 58'sd359858176, 58'sd202932224
	};
	localparam acc_t SAT_COEF [N_STEP+1] = '{
		-58'sd107125146, 58'sd939851776, -58'sd3293773824,
		58'sd5831196672, -58'sd5869731840, 58'sd3857252352
	};

	// truncating log2 in q24, evaluated at elaboration only
	function automatic log_t log2_q24_f(input logic [31:0] x);
		logic [4:0] e;
		logic [63:0] m;
		logic [23:0] frac;
		e = '0;
		for (int i = 1; i < 32; i++) begin
			if (x[i]) e = 5'(i);
		end
		if (e == 5'd31) m = 64'(x) >> 1;
		else m = 64'(x) << (5'd30 - e);
		frac = '0;
		for (int i = 0; i < 24; i++) begin
			m = (m * m) >> 30;
			frac = {frac[22:0], 1'b0};
			if (m >= 64'h8000_0000) begin
				frac[0] = 1'b1;
				m = m >> 1;
			end
		end
		return {e, frac};
	endfunction

	localparam log_t LOG_REF = log2_q24_f(32'd5505024);

	function automatic logic [56:0] acc_mag(input acc_t v);
		acc_t n;
		n = -v;
		return v[57] ? n[56:0] : v[56:0];
	endfunction

	function automatic logic [30:0] p_mag(input p_t v);
		p_t n;
		n = -v;
		return v[31] ? n[30:0] : v[30:0];
	endfunction

endpackage

[rtl/tcd_log2.sv]
// pipelined log2 in q24: normalize stage then one squaring stage per fraction bit
`timescale 1ns / 1ps
module tcd_log2 (
	input  logic          clk,
	input  logic          en,
	input  logic [31:0]   x,
	output tcd_pkg::log_t lg
);
	localparam int STEPS = 24;

	logic [4:0]  e_s    [0:STEPS];
	logic [30:0] m_s    [0:STEPS];
	logic [23:0] frac_s [0:STEPS];

	logic [4:0]  e_c;
	logic [30:0] m_c;

	always_comb begin
		e_c = '0;
		for (int i = 1; i < 32; i++) begin
			if (x[i]) e_c = 5'(i);
		end
		if (e_c == 5'd31) m_c = x[31:1];
		else m_c = 31'(x << (5'd30 - e_c));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s[0]    <= e_c;
			m_s[0]    <= m_c;
			frac_s[0] <= '0;
		end
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_sq
		logic [61:0] sq;
		logic [31:0] m2;
		assign sq = 62'(m_s[k]) * 62'(m_s[k]);
		assign m2 = sq[61:30];
		always_ff @(posedge clk) begin
			if (en) begin
				e_s[k+1]    <= e_s[k];
				frac_s[k+1] <= {frac_s[k][22:0], m2[31]};
				m_s[k+1]    <= m2[31] ? m2[31:1] : m2[30:0];
			end
		end
	end

	assign lg = {e_s[STEPS], frac_s[STEPS]};

endmodule

[rtl/tcd_sqrt.sv]
// pipelined floor square root of d * 2^36, one result bit per stage
`timescale 1ns / 1ps
module tcd_sqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [25:0] d,
	output logic [30:0] root
);
	localparam int STEPS = 31;

	logic [25:0] d_s    [0:STEPS-1];
	logic [32:0] rem_s  [0:STEPS-1];
	logic [30:0] root_s [0:STEPS-1];

	for (genvar k = 0; k < STEPS; k++) begin : g_bit
		localparam int PI = STEPS - 1 - k;
		logic [25:0] d_in;
		logic [32:0] rem_in;
		logic [30:0] root_in;
		logic [61:0] v;
		logic [34:0] r4;
		logic [34:0] trial;
		logic        ge;
		if (k == 0) begin : g_first
			assign d_in    = d;
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign d_in    = d_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
		end
		assign v     = {d_in, 36'd0};
		assign r4    = {rem_in, v[2*PI+1 -: 2]};
		assign trial = {2'b00, root_in, 2'b01};
		assign ge    = (r4 >= trial);
		always_ff @(posedge clk) begin
			if (en) begin
				d_s[k]    <= d_in;
				rem_s[k]  <= ge ? 33'(r4 - trial) : 33'(r4);
				root_s[k] <= {root_in[29:0], ge};
			end
		end
	end

	assign root = root_s[STEPS-1];

endmodule

[rtl/tuner_cnr_to_db.sv]
// top level: raw carrier-to-noise reading to millidb, fully pipelined
`timescale 1ns / 1ps
// throughput: one item per cycle while out_ready stays high
// a result held with out_ready low freezes the whole pipe; in_ready follows it
// reset: arst_n clears all stage valid bits and system_mode (back to unspecified)
// datapath registers carry no reset
module tuner_cnr_to_db #(
	parameter int RAW_WIDTH = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [1:0]           cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [RAW_WIDTH-1:0] raw_cnr,
	input  logic                 read_ok,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [31:0]   cnr_millidb,
	output logic                 saturated
);
	// stage map
	//   1..25  log2 (normalize + 24 squarings), sqrt runs alongside in 1..31
	//   26..28 terrestrial p = (log2 ref - log2 raw) * log10(2)
	//   29..31 terrestrial p delay
	//   32     p select and first coefficient
	//   33..47 five horner steps, three stages each (multiply, round, add)
	//   48     round to millidb and saturate
	localparam int LOG_ST = 25;
	localparam int P_ST   = 32;
	localparam int LAST   = P_ST + 3 * tcd_pkg::N_STEP + 1;

	logic [1:0] system_mode_q;
	logic       en;

	tcd_pkg::ctl_t ctl_in;
	tcd_pkg::ctl_t ctl_s [1:LAST];

	logic [31:0] raw_x;
	logic [31:0] d_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			system_mode_q <= '0;
		end else if (cfg_wr_en) begin
			system_mode_q <= cfg_wr_data;
		end
	end

	// whole pipe advances unless a finished result is waiting
	assign en       = out_ready || !ctl_s[LAST].valid;
	assign in_ready = en;

	assign raw_x = 32'(raw_cnr);
	assign d_x   = raw_x - tcd_pkg::SAT_OFFSET;

	always_comb begin
		ctl_in.valid  = in_valid;
		ctl_in.is_sat = (system_mode_q == tcd_pkg::MODE_SAT);
		ctl_in.active = read_ok &&
			(((system_mode_q == tcd_pkg::MODE_TERR) && (raw_x != '0)) ||
			 ((system_mode_q == tcd_pkg::MODE_SAT) && (raw_x >= tcd_pkg::SAT_OFFSET)));
		// sqrt(d)/64 reaches 128 here, so p pins to its max
		ctl_in.big = |d_x[31:26];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LAST; k++) ctl_s[k] <= '0;
		end else if (en) begin
			ctl_s[1] <= ctl_in;
			for (int k = 2; k <= LAST; k++) ctl_s[k] <= ctl_s[k-1];
		end
	end

	// log2 and sqrt units both see every item; the mode bit picks one later
	tcd_pkg::log_t lg_out;
	logic [30:0]   root_out;

	tcd_log2 u_log (
		.clk (clk),
		.en  (en),
		.x   (raw_x),
		.lg  (lg_out)
	);

	tcd_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.d    (d_x[25:0]),
		.root (root_out)
	);

	// terrestrial p path
	logic [29:0]   tdiff;
	logic          tneg_s26, tneg_s27;
	logic [28:0]   tmag_s26;
	logic [57:0]   tprod_s27;
	logic [58:0]   tround;
	tcd_pkg::p_t   tp_c;
	tcd_pkg::p_t   tp_s28, tp_s29, tp_s30, tp_s31;

	assign tdiff = {1'b0, tcd_pkg::LOG_REF} - {1'b0, lg_out};

	always_comb begin
		tround = 59'(tprod_s27) + 59'd536870912;
		tp_c   = tneg_s27 ? -(32'(tround[58:30])) : 32'(tround[58:30]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tneg_s26  <= tdiff[29];
			tmag_s26  <= tdiff[29] ? 29'(-tdiff) : tdiff[28:0];
			tneg_s27  <= tneg_s26;
			tprod_s27 <= 58'(tmag_s26) * 58'(tcd_pkg::LOG10_2_Q30);
			tp_s28    <= tp_c;
			tp_s29    <= tp_s28;
			tp_s30    <= tp_s29;
			tp_s31    <= tp_s30;
		end
	end

	// p select, carried alongside the horner steps
	tcd_pkg::p_t  p_s   [P_ST:LAST-1];
	tcd_pkg::acc_t acc_s [0:tcd_pkg::N_STEP];

	always_ff @(posedge clk) begin
		if (en) begin
			if (ctl_s[P_ST-1].is_sat) begin
				p_s[P_ST]  <= ctl_s[P_ST-1].big ? tcd_pkg::P_MAX : {1'b0, root_out};
				acc_s[0]   <= tcd_pkg::SAT_COEF[0];
			end else begin
				p_s[P_ST]  <= tp_s31;
				acc_s[0]   <= tcd_pkg::TERR_COEF[0];
			end
			for (int k = P_ST + 1; k < LAST; k++) p_s[k] <= p_s[k-1];
		end
	end

	// horner: acc = clamp(round(acc * p >> 24) + coef)
	for (genvar j = 1; j <= tcd_pkg::N_STEP; j++) begin : g_step
		localparam int B = P_ST + 3 * (j - 1);
		logic [56:0]   ua;
		logic [30:0]   ub;
		logic [55:0]   hp_s;
		logic [62:0]   lp_s;
		logic          neg_s;
		logic [64:0]   r;
		logic [56:0]   rc;
		tcd_pkg::acc_t rs_s;
		tcd_pkg::acc_t coef;
		logic signed [58:0] sum;

		assign ua = tcd_pkg::acc_mag(acc_s[j-1]);
		assign ub = tcd_pkg::p_mag(p_s[B]);

		// split product: high and low halves of |acc|, each under 32x32
		always_comb begin
			r  = {1'b0, hp_s, 8'd0} + 65'((64'(lp_s) + 64'd8388608) >> 24);
			rc = (r > 65'(tcd_pkg::ACC_LIMIT)) ? 57'(tcd_pkg::ACC_LIMIT) : r[56:0];
		end

		assign coef = ctl_s[B+2].is_sat ? tcd_pkg::SAT_COEF[j] : tcd_pkg::TERR_COEF[j];
		assign sum  = 59'(rs_s) + 59'(coef);

		always_ff @(posedge clk) begin
			if (en) begin
				hp_s  <= 56'(ua[56:32]) * 56'(ub);
				lp_s  <= 63'(ua[31:0]) * 63'(ub);
				neg_s <= acc_s[j-1][57] ^ p_s[B][31];
				rs_s  <= neg_s ? -(58'(rc)) : 58'(rc);
				if (sum > 59'(tcd_pkg::ACC_LIMIT)) acc_s[j] <= tcd_pkg::ACC_LIMIT;
				else if (sum < -59'(tcd_pkg::ACC_LIMIT)) acc_s[j] <= -tcd_pkg::ACC_LIMIT;
				else acc_s[j] <= 58'(sum);
			end
		end
	end

	// final rounding to whole millidb with 32-bit clip
	logic [56:0]        fin_mag;
	logic [57:0]        fin_rnd;
	logic [41:0]        fin_m;
	logic signed [31:0] res_c;
	logic               sat_c;
	logic signed [31:0] res_s48;
	logic               sat_s48;

	always_comb begin
		fin_mag = tcd_pkg::acc_mag(acc_s[tcd_pkg::N_STEP]);
		fin_rnd = 58'(fin_mag) + 58'd32768;
		fin_m   = fin_rnd[57:16];
		res_c   = '0;
		sat_c   = 1'b0;
		if (ctl_s[LAST-1].active) begin
			if (acc_s[tcd_pkg::N_STEP][57]) begin
				if (fin_m > 42'h0_8000_0000) begin
					res_c = 32'sh8000_0000;
					sat_c = 1'b1;
				end else begin
					res_c = 32'(-fin_m);
				end
			end else begin
				if (fin_m > 42'h0_7fff_ffff) begin
					res_c = 32'sh7fff_ffff;
					sat_c = 1'b1;
				end else begin
					res_c = 32'(fin_m);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s48 <= res_c;
			sat_s48 <= sat_c;
		end
	end

	assign out_valid   = ctl_s[LAST].valid;
	assign cnr_millidb = res_s48;
	assign saturated   = sat_s48;

	// inactive items (failed read, bad mode, out-of-range raw) come out as zero
	a_inactive_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s[LAST].valid && !ctl_s[LAST].active) |-> (res_s48 == '0 && !sat_s48))
		else $error("inactive item produced a nonzero result");

	// a clip always lands on one of the two range ends
	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && saturated) |->
			(cnr_millidb == 32'sh7fff_ffff || cnr_millidb == 32'sh8000_0000))
		else $error("saturated flag without a clipped value");

	// input is only held off by a waiting result
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("in_ready low without backpressure");

	// satellite p comes from a square root or is pinned to its max, and is never negative
	a_sat_p_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s[P_ST].valid && ctl_s[P_ST].is_sat) |-> !p_s[P_ST][31])
		else $error("negative p in satellite mode");

endmodule

[dv/testbench.sv]
// testbench for the cnr to db converter: driver, monitor and predictor
`timescale 1ns / 1ps
module testbench;

	localparam int RAW_W = 24;
	localparam int DRAIN_CYCLES = 80;

	typedef struct {
		logic [RAW_W-1:0] raw;
		logic             ok;
	} reading_t;

	typedef struct {
		logic signed [31:0] db;
		logic               sat;
	} db_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [RAW_W-1:0] raw_cnr = '0;
	logic read_ok = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] cnr_millidb;
	logic saturated;

	// predictor state: the mode the block should hold
	logic [1:0] mode_shadow = '0;

	reading_t   pending_readings[$];
	db_result_t expected_db[$];

	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	bit  hold_sender = 1'b0;
	bit  failed = 1'b0;

	tuner_cnr_to_db #(.RAW_WIDTH(RAW_W)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.raw_cnr(raw_cnr), .read_ok(read_ok),
		.out_valid(out_valid), .out_ready(out_ready),
		.cnr_millidb(cnr_millidb), .saturated(saturated)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ---------------- predictor ----------------

	function automatic logic [63:0] abs64(input longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	// truncating log2 in q24 by repeated squaring of the normalized mantissa
	function automatic logic [63:0] log2_fix(input logic [63:0] x);
		int unsigned e;
		logic [63:0] m, frac;
		e = 0;
		while (e < 31 && (x >> (e + 1)) != 0) e++;
		m = (e <= 30) ? (x << (30 - e)) : (x >> 1);
		frac = 0;
		for (int i = 0; i < 24; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= 64'h8000_0000) begin
				frac = frac | 1;
				m = m >> 1;
			end
		end
		return (64'(e) << 24) | frac;
	endfunction

	function automatic logic [63:0] sqrt_floor(input logic [63:0] v);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// acc * p in q24, rounded half away from zero, magnitude capped at 2^56
	function automatic longint scale_q24(input longint a, input longint b);
		logic [63:0] ua, ub, hi, lo, r;
		ua = abs64(a);
		ub = abs64(b);
		hi = ua >> 32;
		lo = ua & 64'hFFFF_FFFF;
		r = ((hi * ub) << 8) + ((lo * ub + (64'd1 << 23)) >> 24);
		if (r > (64'd1 << 56)) r = 64'd1 << 56;
		return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint eval_poly(input longint c[6], input int first,
			input longint p);
		longint acc;
		longint lim;
		lim = longint'(64'd1 << 56);
		acc = c[first];
		for (int i = first + 1; i < 6; i++) begin
			acc = scale_q24(acc, p) + c[i];
			if (acc > lim) acc = lim;
			if (acc < -lim) acc = -lim;
		end
		return acc;
	endfunction

	function automatic db_result_t predict_db(input reading_t rd, input logic [1:0] mode);
		longint terr_c[6] = '{0, 15728640, -104857600, 260833280, 359858176, 202932224};
		longint sat_c[6] = '{-107125146, 939851776, -64'sd3293773824, 64'sd5831196672,
			-64'sd5869731840, 64'sd3857252352};
		db_result_t r;
		longint acc, diff, p;
		logic [63:0] m, d;
		bit active;
		acc = 0;
		active = 1'b0;
		r.db = '0;
		r.sat = 1'b0;
		if (rd.ok && mode == tcd_pkg::MODE_TERR && rd.raw != 0) begin
			diff = longint'(log2_fix(64'd5505024)) - longint'(log2_fix(64'(rd.raw)));
			m = (abs64(diff) * 64'd323228497 + (64'd1 << 29)) >> 30;
			p = diff < 0 ? -longint'(m) : longint'(m);
			acc = eval_poly(terr_c, 1, p);
			active = 1'b1;
		end else if (rd.ok && mode == tcd_pkg::MODE_SAT && rd.raw >= 3000) begin
			d = 64'(rd.raw) - 64'd3000;
			if (d >= (64'd1 << 26)) begin
				p = 64'h7FFF_FFFF;
			end else begin
				m = sqrt_floor(d << 36);
				if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
				p = longint'(m);
			end
			acc = eval_poly(sat_c, 0, p);
			active = 1'b1;
		end
		if (active) begin
			m = (abs64(acc) + 64'd32768) >> 16;
			if (acc < 0) begin
				if (m > 64'd2147483648) begin
					m = 64'd2147483648;
					r.sat = 1'b1;
				end
				r.db = 32'(-longint'(m));
			end else begin
				if (m > 64'd2147483647) begin
					m = 64'd2147483647;
					r.sat = 1'b1;
				end
				r.db = 32'(m);
			end
		end
		return r;
	endfunction

	// ---------------- driver ----------------

	// a new valid is raised only from a clean state, payload held until the transfer
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			expected_db.push_back(predict_db('{raw: raw_cnr, ok: read_ok}, mode_shadow));
		end
		if (!in_valid || in_ready) begin
			if (pending_readings.size() > 0 && !hold_sender &&
					$urandom_range(99) >= send_idle_pct) begin
				reading_t rd;
				rd = pending_readings.pop_front();
				in_valid <= 1'b1;
				raw_cnr <= rd.raw;
				read_ok <= rd.ok;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ---------------- monitor ----------------

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (expected_db.size() == 0) begin
				$error("unexpected result transfer: cnr_millidb %0d", cnr_millidb);
				failed = 1'b1;
			end else begin
				db_result_t want;
				want = expected_db.pop_front();
				if (cnr_millidb !== want.db) begin
					$error("cnr_millidb: expected %0d actual %0d", want.db, cnr_millidb);
					failed = 1'b1;
				end
				if (saturated !== want.sat) begin
					$error("saturated: expected %0b actual %0b", want.sat, saturated);
					failed = 1'b1;
				end
			end
		end
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// ---------------- stimulus ----------------

	task automatic queue_reading(input logic [RAW_W-1:0] raw, input logic ok);
		pending_readings.push_back('{raw: raw, ok: ok});
	endtask

	// wait for every queued reading to transfer and every result to arrive
	task automatic drain();
		while (pending_readings.size() > 0 || in_valid || expected_db.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_mode(input logic [1:0] mode);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= mode;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		mode_shadow = mode;
	endtask

	// mostly realistic readings, with raw values spread over every bit width
	function automatic logic [RAW_W-1:0] random_raw();
		int sel;
		sel = $urandom_range(9);
		if (sel < 3) return RAW_W'($urandom_range(6000, 0));
		if (sel < 6) return RAW_W'($urandom_range(200000, 1));
		if (sel < 8) return RAW_W'($urandom) >> $urandom_range(RAW_W - 1);
		return RAW_W'($urandom);
	endfunction

	task automatic random_phase(input int count, input int idle_pct, input int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < count; i++)
			queue_reading(random_raw(), $urandom_range(15) != 0);
		drain();
	endtask

	task automatic directed_set();
		queue_reading('0, 1'b1);
		queue_reading(24'd1, 1'b1);
		queue_reading(24'd2999, 1'b1);
		queue_reading(24'd3000, 1'b1);
		queue_reading(24'd3001, 1'b1);
		queue_reading(24'd5505024, 1'b1);
		queue_reading(24'd5505024, 1'b0);
		queue_reading('1, 1'b1);
		queue_reading('1, 1'b0);
		queue_reading(24'h800000, 1'b1);
		queue_reading(24'h555555, 1'b1);
		queue_reading(24'hAAAAAA, 1'b1);
		queue_reading(24'd100000, 1'b1);
		drain();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset mode is unspecified: everything reads as zero
		directed_set();
		for (int m = 0; m < 4; m++) begin
			set_mode(2'(m));
			directed_set();
		end

		// several idle and stall profiles for the two real modes, one each for the extremes of the register
		set_mode(tcd_pkg::MODE_TERR);
		random_phase(250, 0, 0);
		random_phase(150, 50, 0);
		// sender holds off with a reading queued and the pipe empty, then resumes
		hold_sender = 1'b1;
		queue_reading(24'd12345, 1'b1);
		repeat (60) @(posedge clk);
		hold_sender = 1'b0;
		drain();
		set_mode(tcd_pkg::MODE_SAT);
		random_phase(250, 0, 0);
		random_phase(200, 0, 50);
		random_phase(200, 13, 13);
		set_mode(2'd0);
		random_phase(100, 13, 13);
		set_mode(2'd3);
		random_phase(100, 50, 50);
		set_mode(tcd_pkg::MODE_TERR);
		random_phase(200, 13, 13);
		random_phase(150, 0, 50);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!failed && expected_db.size() == 0) begin
			$display("testbench: PASS");
		end else begin
			if (expected_db.size() != 0)
				$error("%0d expected results never arrived", expected_db.size());
			$display("testbench: FAIL");
		end
		$finish;
	end

	// watchdog: far beyond the slowest correct run
	initial begin
		#5ms;
		$display("testbench: FAIL");
		$finish;
	end

endmodule

[tuner_cnr_to_db.f]
rtl/tcd_pkg.sv
rtl/tcd_log2.sv
rtl/tcd_sqrt.sv
rtl/tuner_cnr_to_db.sv
dv/testbench.sv
